### rtl/wsr_pkg.sv
// Shared types and constants for the WebSocket text frame receiver.
// No dependencies; the receiver modules import this package.
package wsr_pkg;

	// Largest payload length that is accepted
	localparam int unsigned PAYLOAD_LIMIT = 8192;
	// Payload index width: holds counts up to PAYLOAD_LIMIT
	localparam int unsigned IDX_W = $clog2(PAYLOAD_LIMIT + 1);

	localparam logic [3:0] OPCODE_TEXT = 4'h1;
	localparam logic [6:0] LEN_EXT16   = 7'd126;
	localparam logic [6:0] LEN_EXT64   = 7'd127;

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXT16,
		PH_EXT64,
		PH_MASK,
		PH_DATA,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA,
		KIND_REJECT,
		KIND_EARLY
	} kind_t;

	// One queued action from the front part to the back part
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic [7:0] mask;
		logic       last;
	} qent_t;

	// Queue status seen by the back part
	typedef struct packed {
		logic  not_empty;
		qent_t head;
	} qstat_t;

endpackage

### rtl/wsr_in_if.sv
// Input channel of the frame receiver: one socket byte or a close event.
// Depends on nothing.
interface wsr_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] byte_value;

	modport source (output valid, output op, output byte_value, input ready);
	modport sink   (input valid, input op, input byte_value, output ready);
endinterface

### rtl/wsr_out_if.sv
// Result channel of the frame receiver: payload bytes and error results.
// Depends on nothing.
interface wsr_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] payload_byte;
	logic       is_last;

	modport source (output valid, output kind, output payload_byte, output is_last,
		input ready);
	modport sink   (input valid, input kind, input payload_byte, input is_last,
		output ready);
endinterface

### rtl/websocket_text_frame_receiver_unit.sv
// WebSocket text frame receiver: parses the first frame of a byte stream.
// Throughput: one input item per cycle, set by the single-byte header parser,
// while the queue is not full. An accepted item is written into the queue and
// then loaded into the back part's result register when it is free or drains.
// Reset: asynchronous; the parser expects the first header byte and the queue
// and result register are empty.
module websocket_text_frame_receiver_unit (
	input  logic      clk,
	input  logic      arst_n,
	wsr_in_if.sink    rx,
	wsr_out_if.source res
);
	import wsr_pkg::*;

	logic   q_push;
	qent_t  q_data;
	logic   q_full;
	logic   q_pop;
	qstat_t q_stat;

	wsr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_data)
	);

	wsr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.pop       (q_pop),
		.full      (q_full),
		.stat      (q_stat)
	);

	wsr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (q_stat),
		.pop    (q_pop),
		.res    (res)
	);

endmodule

### rtl/wsr_front.sv
// Front part: accepts input items, parses the frame header, classifies bytes.
// Depends on wsr_pkg and wsr_in_if.
module wsr_front (
	input  logic          clk,
	input  logic          arst_n,
	wsr_in_if.sink        rx,
	input  logic          q_full,
	output logic          q_push,
	output wsr_pkg::qent_t q_data
);
	import wsr_pkg::*;

	phase_t            phase_q, phase_d;
	logic [3:0]        opcode_q, opcode_d;
	logic              mask_present_q, mask_present_d;
	logic [63:0]       len_q, len_d;
	logic [2:0]        cnt_q, cnt_d;
	logic [31:0]       key_q, key_d;
	logic [IDX_W-1:0]  idx_q, idx_d;

	logic              accept;
	logic              live;
	logic [7:0]        b;
	logic [6:0]        len7;
	logic [63:0]       len_shift;
	logic [63:0]       hdr_len;
	logic              hdr_ok;
	logic              len_end;
	logic              hdr_end;
	logic [IDX_W:0]    idx_inc;
	logic              last_data;
	logic [7:0]        mask_byte;

	assign rx.ready  = !q_full;
	assign accept    = rx.valid && rx.ready;
	assign live      = accept && (phase_q != PH_DONE);
	assign b         = rx.byte_value;
	assign len7      = b[6:0];
	assign len_shift = {len_q[55:0], b};

	// Classify the current byte against the header layout
	always_comb begin
		len_end = 1'b0;
		hdr_end = 1'b0;
		hdr_len = len_shift;
		case (phase_q)
			PH_HDR1: begin
				hdr_len = {57'd0, len7};
				len_end = (len7 != LEN_EXT16) && (len7 != LEN_EXT64);
				hdr_end = len_end && !b[7];
			end
			PH_EXT16: begin
				len_end = (cnt_q == 3'd1);
				hdr_end = len_end && !mask_present_q;
			end
			PH_EXT64: begin
				len_end = (cnt_q == 3'd7);
				hdr_end = len_end && !mask_present_q;
			end
			PH_MASK: begin
				hdr_len = len_q;
				hdr_end = (cnt_q == 3'd3);
			end
			default: ;
		endcase
		hdr_ok = (opcode_q == OPCODE_TEXT) && (hdr_len != 64'd0) &&
			(hdr_len <= 64'(PAYLOAD_LIMIT));
	end

	// Select the mask byte and detect the final payload byte
	assign idx_inc   = {1'b0, idx_q} + {{IDX_W{1'b0}}, 1'b1};
	assign last_data = (64'(idx_inc) >= len_q);

	always_comb begin
		case (idx_q[1:0])
			2'd0:    mask_byte = key_q[31:24];
			2'd1:    mask_byte = key_q[23:16];
			2'd2:    mask_byte = key_q[15:8];
			default: mask_byte = key_q[7:0];
		endcase
	end

	// Next state and header registers
	always_comb begin
		phase_d        = phase_q;
		opcode_d       = opcode_q;
		mask_present_d = mask_present_q;
		len_d          = len_q;
		cnt_d          = cnt_q;
		key_d          = key_q;
		idx_d          = idx_q;
		if (live) begin
			if (rx.op) begin
				phase_d = PH_DONE;
			end else begin
				unique case (phase_q)
					PH_HDR0: begin
						opcode_d = b[3:0];
						phase_d  = PH_HDR1;
					end
					PH_HDR1: begin
						mask_present_d = b[7];
						len_d          = {57'd0, len7};
						cnt_d          = 3'd0;
						if (len7 == LEN_EXT16) begin
							len_d   = 64'd0;
							phase_d = PH_EXT16;
						end else if (len7 == LEN_EXT64) begin
							len_d   = 64'd0;
							phase_d = PH_EXT64;
						end else if (b[7]) begin
							phase_d = PH_MASK;
						end else begin
							idx_d   = '0;
							phase_d = hdr_ok ? PH_DATA : PH_DONE;
						end
					end
					PH_EXT16, PH_EXT64: begin
						len_d = len_shift;
						cnt_d = cnt_q + 3'd1;
						if (len_end) begin
							cnt_d = 3'd0;
							if (mask_present_q) begin
								phase_d = PH_MASK;
							end else begin
								idx_d   = '0;
								phase_d = hdr_ok ? PH_DATA : PH_DONE;
							end
						end
					end
					PH_MASK: begin
						key_d = {key_q[23:0], b};
						cnt_d = cnt_q + 3'd1;
						if (hdr_end) begin
							cnt_d   = 3'd0;
							idx_d   = '0;
							phase_d = hdr_ok ? PH_DATA : PH_DONE;
						end
					end
					PH_DATA: begin
						idx_d = idx_inc[IDX_W-1:0];
						if (last_data) begin
							phase_d = PH_DONE;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Queue push for results
	always_comb begin
		q_push      = 1'b0;
		q_data.kind = KIND_DATA;
		q_data.data = 8'd0;
		q_data.mask = 8'd0;
		q_data.last = 1'b1;
		if (live) begin
			if (rx.op) begin
				q_push      = 1'b1;
				q_data.kind = KIND_EARLY;
			end else if (phase_q == PH_DATA) begin
				q_push      = 1'b1;
				q_data.data = b;
				q_data.mask = mask_byte;
				q_data.last = last_data;
			end else if (hdr_end && !hdr_ok) begin
				q_push      = 1'b1;
				q_data.kind = KIND_REJECT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HDR0;
			opcode_q       <= 4'd0;
			mask_present_q <= 1'b0;
			len_q          <= 64'd0;
			cnt_q          <= 3'd0;
			key_q          <= 32'd0;
			idx_q          <= '0;
		end else begin
			phase_q        <= phase_d;
			opcode_q       <= opcode_d;
			mask_present_q <= mask_present_d;
			len_q          <= len_d;
			cnt_q          <= cnt_d;
			key_q          <= key_d;
			idx_q          <= idx_d;
		end
	end

endmodule

### rtl/wsr_queue.sv
// Two-entry queue between the front and back parts of the receiver.
// Depends on wsr_pkg.
module wsr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  wsr_pkg::qent_t  push_data,
	input  logic            pop,
	output logic            full,
	output wsr_pkg::qstat_t stat
);
	import wsr_pkg::*;

	qent_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full           = (count_q == 2'd2);
	assign stat.not_empty = (count_q != 2'd0);
	assign stat.head      = ent_q[rd_ptr_q];

	// Store pushed item
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/wsr_back.sv
// Back part: unmasks queued payload bytes and holds the result register.
// Depends on wsr_pkg and wsr_out_if.
module wsr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  wsr_pkg::qstat_t stat,
	output logic            pop,
	wsr_out_if.source       res
);
	import wsr_pkg::*;

	logic       valid_q;
	logic [1:0] kind_q;
	logic [7:0] byte_q;
	logic       last_q;

	// Take the head item when the result register is free or drains
	assign pop = stat.not_empty && (!valid_q || res.ready);

	assign res.valid        = valid_q;
	assign res.kind         = kind_q;
	assign res.payload_byte = byte_q;
	assign res.is_last      = last_q;

	// Load unmasked result
	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= stat.head.kind;
			byte_q <= stat.head.data ^ stat.head.mask;
			last_q <= stat.head.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule
